[src/ssa_pkg.sv]
package ssa_pkg;

    localparam int MAX_SLABS  = 16;
    localparam int MAX_SLOTS  = 64;
    localparam int SLAB_W     = 4;
    localparam int SLOT_W     = 6;
    localparam int HANDLE_W   = 10;
    localparam int CNT_W      = 7;
    localparam int MAPPED_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_SLAB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SLABS      = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [CNT_W-1:0]    slot_count;
        logic [HANDLE_W-1:0] slot_handle;
    } ssa_in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        logic                ok;
        logic                last;
        logic [MAPPED_W-1:0] slabs_mapped;
    } ssa_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_CHECK,
        ST_MAP_INIT,
        ST_ALLOC_READ,
        ST_ALLOC_LINK,
        ST_ALLOC_WRITE,
        ST_FREE_READ,
        ST_FREE_WRITE
    } ssa_state_t;

endpackage

[src/slab_slot_allocator_top.sv]
// Slab slot allocator. Pulse start while busy is low to issue a transaction:
// an allocate produces one result per granted slot in grant order (plus a
// failing result with ok low when no slab can be mapped), a free produces one
// result. Each result is presented on result for exactly one cycle with
// result_valid high; the receiver cannot stall, so it must take every strobe.
// The last result of a transaction has last set. For each granted slot an
// allocate checks the partial stack, reads the slab head and count, reads the
// link memory, then writes back. Mapping a fresh slab lays out its free list
// slot by slot, then reads the partial stack again. A failing result ends the
// transaction; an allocate of zero slots is taken without going busy. A free
// reads the slab head and count, then writes back. Each result appears the
// cycle after the step that makes it. The user must write configuration via
// cfg_we/cfg_index/cfg_data only while busy is low; the block does not check.
module slab_slot_allocator_top
    import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ssa_in_t               cmd_in,
    output logic                  result_valid,
    output ssa_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // memories
    logic [SLOT_W-1:0] link_mem [MAX_SLABS*MAX_SLOTS];
    logic [SLOT_W-1:0] head_mem [MAX_SLABS];
    logic [CNT_W-1:0]  count_mem [MAX_SLABS];
    logic [SLAB_W-1:0] stack_mem [MAX_SLABS];

    ssa_state_t state_reg, state_next;

    logic [CNT_W-1:0]    spslab_reg;
    logic [MAPPED_W-1:0] maxslab_reg;
    logic [MAPPED_W-1:0] depth_reg, depth_next;
    logic [MAPPED_W-1:0] mapped_reg, mapped_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SLAB_W-1:0]   slab_reg, slab_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    init_reg, init_next;
    logic [CNT_W-1:0]    eff_map_reg;

    logic [SLAB_W-1:0]   top_rd;
    logic [SLOT_W-1:0]   head_rd;
    logic [CNT_W-1:0]    count_rd;
    logic [SLOT_W-1:0]   link_rd;

    logic [CNT_W-1:0]    eff_slots;
    logic [MAPPED_W-1:0] eff_limit;
    logic [CNT_W-1:0]    want;

    // memory control
    logic                link_we;
    logic [HANDLE_W-1:0] link_wa;
    logic [SLOT_W-1:0]   link_wd;
    logic [HANDLE_W-1:0] link_ra;
    logic                hc_we;
    logic [SLAB_W-1:0]   hc_wa;
    logic [SLOT_W-1:0]   head_wd;
    logic [CNT_W-1:0]    count_wd;
    logic [SLAB_W-1:0]   hc_ra;
    logic                stk_we;
    logic [SLAB_W-1:0]   stk_wa;
    logic [SLAB_W-1:0]   stk_wd;
    logic [SLAB_W-1:0]   stk_ra;

    logic                out_valid_next;
    ssa_out_t            out_next;
    logic                fail_map;

    always_comb
    begin
        eff_slots = spslab_reg;
        if (spslab_reg == '0)
            eff_slots = CNT_W'(1);
        else if (spslab_reg > CNT_W'(MAX_SLOTS))
            eff_slots = CNT_W'(MAX_SLOTS);
        eff_limit = (maxslab_reg > MAPPED_W'(MAX_SLABS)) ? MAPPED_W'(MAX_SLABS) : maxslab_reg;
        want = (cmd_in.slot_count > CNT_W'(64)) ? CNT_W'(64) : cmd_in.slot_count;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        link_rd <= link_mem[link_ra];
        if (hc_we)
        begin
            head_mem[hc_wa]  <= head_wd;
            count_mem[hc_wa] <= count_wd;
        end
        head_rd  <= head_mem[hc_ra];
        count_rd <= count_mem[hc_ra];
        top_rd <= stack_mem[stk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_wa] <= stk_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            spslab_reg   <= CNT_W'(64);
            maxslab_reg  <= MAPPED_W'(16);
            depth_reg    <= '0;
            mapped_reg   <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            mapped_reg   <= mapped_next;
            result_valid <= out_valid_next;
            if (cfg_we && cfg_index == REG_SLOTS_PER_SLAB)
                spslab_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_MAX_SLABS)
                maxslab_reg <= cfg_data[MAPPED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result   <= out_next;
        left_reg <= left_next;
        slab_reg <= slab_next;
        slot_reg <= slot_next;
        cnt_reg  <= cnt_next;
        init_reg <= init_next;
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg     <= cmd_in.cmd;
            handle_reg  <= cmd_in.slot_handle;
        end
        if (state_reg == ST_ALLOC_CHECK)
            eff_map_reg <= eff_slots;
    end

    assign busy = (state_reg != ST_IDLE);
    assign fail_map = (mapped_reg >= eff_limit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    if (cmd_in.cmd == CMD_FREE)
                        state_next = ST_FREE_READ;
                    else if (want != '0)
                        state_next = ST_ALLOC_CHECK;
                end
            ST_ALLOC_CHECK:
                if (depth_reg != '0)
                    state_next = ST_ALLOC_READ;
                else if (fail_map)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MAP_INIT;
            ST_MAP_INIT:
                // re-read the stack top once the new slab is pushed
                if (init_reg + CNT_W'(1) >= eff_map_reg)
                    state_next = ST_ALLOC_CHECK;
            ST_ALLOC_READ:
                state_next = ST_ALLOC_LINK;
            ST_ALLOC_LINK:
                state_next = ST_ALLOC_WRITE;
            ST_ALLOC_WRITE:
                state_next = (left_reg == CNT_W'(1)) ? ST_IDLE : ST_ALLOC_CHECK;
            ST_FREE_READ:
                state_next = ST_FREE_WRITE;
            ST_FREE_WRITE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        logic [CNT_W-1:0] cnt_dec;
        logic             bad;
        cnt_dec        = '0;
        bad            = 1'b0;
        depth_next     = depth_reg;
        mapped_next    = mapped_reg;
        left_next      = left_reg;
        slab_next      = slab_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        out_valid_next = 1'b0;
        out_next       = result;
        link_we        = 1'b0;
        link_wa        = '0;
        link_wd        = '0;
        link_ra        = {slab_reg, slot_reg};
        hc_we          = 1'b0;
        hc_wa          = slab_reg;
        head_wd        = '0;
        count_wd       = '0;
        hc_ra          = slab_reg;
        stk_we         = 1'b0;
        stk_wa         = '0;
        stk_wd         = '0;
        stk_ra         = SLAB_W'(depth_reg - MAPPED_W'(1));
        case (state_reg)
            ST_IDLE:
            begin
                left_next = want;
                hc_ra     = cmd_in.slot_handle[HANDLE_W-1:SLOT_W];
                slab_next = cmd_in.slot_handle[HANDLE_W-1:SLOT_W];
                slot_next = cmd_in.slot_handle[SLOT_W-1:0];
            end
            ST_ALLOC_CHECK:
            begin
                init_next = '0;
                if (depth_reg == '0)
                begin
                    if (fail_map)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '{granted_handle: '0, ok: 1'b0, last: 1'b1,
                                     slabs_mapped: mapped_reg};
                    end
                    else
                    begin
                        slab_next = SLAB_W'(mapped_reg);
                    end
                end
            end
            ST_MAP_INIT:
            begin
                // lay out the fresh slab's list 0,1,..,s-1 then wrap to 0
                link_we = 1'b1;
                link_wa = {slab_reg, init_reg[SLOT_W-1:0]};
                link_wd = (init_reg + CNT_W'(1) < eff_map_reg) ?
                          SLOT_W'(init_reg + CNT_W'(1)) : '0;
                init_next = init_reg + CNT_W'(1);
                if (init_reg + CNT_W'(1) >= eff_map_reg)
                begin
                    hc_we       = 1'b1;
                    head_wd     = '0;
                    count_wd    = eff_map_reg;
                    stk_we      = 1'b1;
                    stk_wa      = SLAB_W'(depth_reg);
                    stk_wd      = slab_reg;
                    depth_next  = depth_reg + MAPPED_W'(1);
                    mapped_next = mapped_reg + MAPPED_W'(1);
                end
            end
            ST_ALLOC_READ:
            begin
                // top_rd valid now; fetch slab head/count
                slab_next = top_rd;
                hc_ra     = top_rd;
            end
            ST_ALLOC_LINK:
            begin
                slot_next = head_rd;
                cnt_next  = count_rd;
                link_ra   = {slab_reg, head_rd};
            end
            ST_ALLOC_WRITE:
            begin
                cnt_dec  = (cnt_reg != '0) ? cnt_reg - CNT_W'(1) : '0;
                hc_we    = 1'b1;
                head_wd  = link_rd;
                count_wd = cnt_dec;
                if (cnt_dec == '0)
                    depth_next = depth_reg - MAPPED_W'(1);
                left_next      = left_reg - CNT_W'(1);
                out_valid_next = 1'b1;
                out_next = '{granted_handle: {slab_reg, slot_reg}, ok: 1'b1,
                             last: (left_reg == CNT_W'(1)), slabs_mapped: mapped_reg};
            end
            ST_FREE_READ:
            begin
                hc_ra = slab_reg;
            end
            ST_FREE_WRITE:
            begin
                bad = (MAPPED_W'(slab_reg) >= mapped_reg) ||
                      (CNT_W'(slot_reg) >= eff_slots) || (count_rd >= eff_slots);
                if (!bad)
                begin
                    link_we  = 1'b1;
                    link_wa  = {slab_reg, slot_reg};
                    link_wd  = head_rd;
                    hc_we    = 1'b1;
                    head_wd  = slot_reg;
                    count_wd = count_rd + CNT_W'(1);
                    if (count_rd == '0 && depth_reg < MAPPED_W'(MAX_SLABS))
                    begin
                        stk_we     = 1'b1;
                        stk_wa     = SLAB_W'(depth_reg);
                        stk_wd     = slab_reg;
                        depth_next = depth_reg + MAPPED_W'(1);
                    end
                end
                out_valid_next = 1'b1;
                out_next = '{granted_handle: handle_reg, ok: !bad, last: 1'b1,
                             slabs_mapped: mapped_reg};
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= MAPPED_W'(MAX_SLABS))
        else $error("partial depth overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        mapped_reg <= MAPPED_W'(MAX_SLABS))
        else $error("mapped count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= mapped_reg)
        else $error("more partial slabs than mapped");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("busy during last result");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ok && cmd_reg == CMD_ALLOC |-> result.last)
        else $error("allocate failure not final");

endmodule
